// File: rtl/xmr_pkg.sv
// Shared types, protocol codes and the CRC-16 byte update for the XMODEM receiver.
`default_nettype none

package xmr_pkg;

    // Protocol phases of the receiver
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC,
        PH_SYNC_CAN,
        PH_NUM,
        PH_COMP,
        PH_DATA,
        PH_CHECK
    } t_phase;

    // Byte sent to poll the sender while synchronizing
    typedef enum logic [1:0] {
        POLL_C,
        POLL_NAK,
        POLL_NONE
    } t_poll;

    // Input event codes
    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_BYTE    = 2'd1,
        ACT_TIMEOUT = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    // Control characters
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;

    // Transfer status codes
    localparam logic [2:0] ST_RUNNING   = 3'd0;
    localparam logic [2:0] ST_COMPLETED = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_SYNC_ERR  = 3'd3;
    localparam logic [2:0] ST_RETRIES   = 3'd4;

    // Packet verdict codes
    localparam logic [1:0] VD_NONE     = 2'd0;
    localparam logic [1:0] VD_NEW      = 2'd1;
    localparam logic [1:0] VD_DUP      = 2'd2;
    localparam logic [1:0] VD_REJECTED = 2'd3;

    // Configuration register indexes
    localparam logic REG_MAX_RETRANS = 1'b0;
    localparam logic REG_SYNC_TRIES  = 1'b1;

    localparam logic [7:0]  MAX_RETRANS_RESET = 8'd25;
    localparam logic [7:0]  SYNC_TRIES_RESET  = 8'd16;
    localparam logic [10:0] SMALL_BLOCK_BYTES = 11'd128;
    localparam logic [15:0] CRC_POLY          = 16'h1021;

    // Results of one request: the first one described here, followed by
    // two more CAN bytes when cnt is three
    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [1:0]  verdict;
        logic [2:0]  status;
        logic [31:0] total;
        logic [1:0]  cnt;
    } t_pack;

    // CRC-16 (poly 0x1021), high bit first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/xmr_core.sv
// Protocol state and per-request result computation of the XMODEM receiver.
`default_nettype none

module xmr_core
    import xmr_pkg::*;
#(
    parameter int LARGE_BLOCK_BYTES = 1024
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic [7:0] i_max_retrans,
    input  wire logic [7:0] i_sync_tries,
    output t_pack           o_pack,
    output logic            o_push
);

    localparam logic [10:0] LARGE_SIZE = 11'(LARGE_BLOCK_BYTES);

    t_phase      r_phase,        n_phase;
    t_poll       r_poll,         n_poll;
    logic        r_crc_mode,     n_crc_mode;
    logic [7:0]  r_try_count,    n_try_count;
    logic [7:0]  r_retrans_left, n_retrans_left;
    logic [7:0]  r_expected,     n_expected;
    logic        r_large,        n_large;
    logic [10:0] r_byte_pos,     n_byte_pos;
    logic [7:0]  r_hdr_num,      n_hdr_num;
    logic        r_hdr_ok,       n_hdr_ok;
    logic [15:0] r_crc_acc,      n_crc_acc;
    logic [15:0] r_rcv_check,    n_rcv_check;
    logic [31:0] r_byte_total,   n_byte_total;
    logic [2:0]  r_end_status,   n_end_status;

    logic        do_miss;
    logic        do_finish;
    logic        good;
    logic [10:0] size;
    logic [10:0] pos_inc;
    logic [7:0]  try_inc;
    logic [32:0] total_sum;
    t_pack       pack;
    logic        push;

    assign size      = r_large ? LARGE_SIZE : SMALL_BLOCK_BYTES;
    assign pos_inc   = r_byte_pos + 11'd1;
    assign try_inc   = r_try_count + 8'd1;
    assign total_sum = {1'b0, r_byte_total} + {22'd0, size};

    // Next state and results of one request
    always_comb begin
        n_phase        = r_phase;
        n_poll         = r_poll;
        n_crc_mode     = r_crc_mode;
        n_try_count    = r_try_count;
        n_retrans_left = r_retrans_left;
        n_expected     = r_expected;
        n_large        = r_large;
        n_byte_pos     = r_byte_pos;
        n_hdr_num      = r_hdr_num;
        n_hdr_ok       = r_hdr_ok;
        n_crc_acc      = r_crc_acc;
        n_rcv_check    = r_rcv_check;
        n_byte_total   = r_byte_total;
        n_end_status   = r_end_status;
        do_miss        = 1'b0;
        do_finish      = 1'b0;
        good           = 1'b0;
        push           = 1'b0;
        pack           = '0;
        pack.cnt       = 2'd1;

        // Event decode
        unique case (t_action'(i_action))
            ACT_START: begin
                n_phase        = PH_SYNC;
                n_poll         = POLL_C;
                n_crc_mode     = 1'b0;
                n_try_count    = 8'd0;
                n_retrans_left = i_max_retrans;
                n_expected     = 8'd1;
                n_large        = 1'b0;
                n_byte_pos     = 11'd0;
                n_hdr_num      = 8'd0;
                n_hdr_ok       = 1'b0;
                n_crc_acc      = 16'd0;
                n_rcv_check    = 16'd0;
                n_byte_total   = 32'd0;
                n_end_status   = ST_RUNNING;
                push           = 1'b1;
                pack.tx_valid  = 1'b1;
                pack.tx_byte   = CH_C;
            end
            ACT_TIMEOUT: begin
                if (r_phase == PH_SYNC || r_phase == PH_SYNC_CAN) begin
                    do_miss = 1'b1;
                end else if (r_phase != PH_IDLE) begin
                    do_finish = 1'b1;
                end
            end
            ACT_BYTE: begin
                unique case (r_phase)
                    PH_SYNC: begin
                        if (i_rx_byte == CH_SOH || i_rx_byte == CH_STX) begin
                            if (r_poll == POLL_C) begin
                                n_crc_mode = 1'b1;
                            end
                            n_poll  = POLL_NONE;
                            n_large = (i_rx_byte == CH_STX);
                            n_phase = PH_NUM;
                        end else if (i_rx_byte == CH_EOT) begin
                            push          = 1'b1;
                            pack.tx_valid = 1'b1;
                            pack.tx_byte  = CH_ACK;
                            n_end_status  = ST_COMPLETED;
                            n_phase       = PH_IDLE;
                        end else if (i_rx_byte == CH_CAN) begin
                            n_phase = PH_SYNC_CAN;
                        end else begin
                            do_miss = 1'b1;
                        end
                    end
                    PH_SYNC_CAN: begin
                        if (i_rx_byte == CH_CAN) begin
                            push          = 1'b1;
                            pack.tx_valid = 1'b1;
                            pack.tx_byte  = CH_ACK;
                            n_end_status  = ST_CANCELLED;
                            n_phase       = PH_IDLE;
                        end else begin
                            do_miss = 1'b1;
                        end
                    end
                    PH_NUM: begin
                        n_hdr_num = i_rx_byte;
                        n_phase   = PH_COMP;
                    end
                    PH_COMP: begin
                        n_hdr_ok   = (r_hdr_num == ~i_rx_byte) &&
                                     (r_hdr_num == r_expected ||
                                      r_hdr_num == r_expected - 8'd1);
                        n_crc_acc  = 16'd0;
                        n_byte_pos = 11'd0;
                        n_phase    = PH_DATA;
                    end
                    PH_DATA: begin
                        push            = 1'b1;
                        pack.data_valid = 1'b1;
                        pack.data_byte  = i_rx_byte;
                        if (r_crc_mode) begin
                            n_crc_acc = crc16_byte(r_crc_acc, i_rx_byte);
                        end else begin
                            n_crc_acc = {8'd0, r_crc_acc[7:0] + i_rx_byte};
                        end
                        n_byte_pos = pos_inc;
                        if (pos_inc >= size) begin
                            n_byte_pos  = 11'd0;
                            n_rcv_check = 16'd0;
                            n_phase     = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        n_rcv_check = {r_rcv_check[7:0], i_rx_byte};
                        n_byte_pos  = pos_inc;
                        if (pos_inc >= (r_crc_mode ? 11'd2 : 11'd1)) begin
                            do_finish = 1'b1;
                            good      = r_hdr_ok && (n_rcv_check == r_crc_acc);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        // Missed sync attempt: poll again, fall back to NAK, or give up
        if (do_miss) begin
            n_phase     = PH_SYNC;
            n_try_count = try_inc;
            if (try_inc < i_sync_tries) begin
                if (r_poll == POLL_C) begin
                    push          = 1'b1;
                    pack.tx_valid = 1'b1;
                    pack.tx_byte  = CH_C;
                end else if (r_poll == POLL_NAK) begin
                    push          = 1'b1;
                    pack.tx_valid = 1'b1;
                    pack.tx_byte  = CH_NAK;
                end
            end else if (r_poll == POLL_C) begin
                n_poll        = POLL_NAK;
                n_try_count   = 8'd0;
                push          = 1'b1;
                pack.tx_valid = 1'b1;
                pack.tx_byte  = CH_NAK;
            end else begin
                push          = 1'b1;
                pack.tx_valid = 1'b1;
                pack.tx_byte  = CH_CAN;
                pack.cnt      = 2'd3;
                n_end_status  = ST_SYNC_ERR;
                n_phase       = PH_IDLE;
            end
        end

        // End of packet: verdict and reply
        if (do_finish) begin
            n_phase       = PH_SYNC;
            n_try_count   = 8'd0;
            push          = 1'b1;
            pack.tx_valid = 1'b1;
            if (!good) begin
                pack.tx_byte = CH_NAK;
                pack.verdict = VD_REJECTED;
            end else if (r_hdr_num == r_expected) begin
                pack.verdict   = VD_NEW;
                n_byte_total   = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
                n_expected     = r_expected + 8'd1;
                n_retrans_left = i_max_retrans;
                if (i_max_retrans == 8'd0) begin
                    pack.tx_byte = CH_CAN;
                    pack.cnt     = 2'd3;
                    n_end_status = ST_RETRIES;
                    n_phase      = PH_IDLE;
                end else begin
                    pack.tx_byte = CH_ACK;
                end
            end else begin
                pack.verdict = VD_DUP;
                if (r_retrans_left <= 8'd1) begin
                    n_retrans_left = 8'd0;
                    pack.tx_byte   = CH_CAN;
                    pack.cnt       = 2'd3;
                    n_end_status   = ST_RETRIES;
                    n_phase        = PH_IDLE;
                end else begin
                    n_retrans_left = r_retrans_left - 8'd1;
                    pack.tx_byte   = CH_ACK;
                end
            end
        end

        pack.status = n_end_status;
        pack.total  = n_byte_total;
    end

    assign o_pack = pack;
    assign o_push = i_accept && push;

    // State registers, updated on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_poll         <= POLL_C;
            r_crc_mode     <= 1'b0;
            r_try_count    <= 8'd0;
            r_retrans_left <= MAX_RETRANS_RESET;
            r_expected     <= 8'd1;
            r_large        <= 1'b0;
            r_byte_pos     <= 11'd0;
            r_hdr_num      <= 8'd0;
            r_hdr_ok       <= 1'b0;
            r_crc_acc      <= 16'd0;
            r_rcv_check    <= 16'd0;
            r_byte_total   <= 32'd0;
            r_end_status   <= ST_RUNNING;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_poll         <= n_poll;
            r_crc_mode     <= n_crc_mode;
            r_try_count    <= n_try_count;
            r_retrans_left <= n_retrans_left;
            r_expected     <= n_expected;
            r_large        <= n_large;
            r_byte_pos     <= n_byte_pos;
            r_hdr_num      <= n_hdr_num;
            r_hdr_ok       <= n_hdr_ok;
            r_crc_acc      <= n_crc_acc;
            r_rcv_check    <= n_rcv_check;
            r_byte_total   <= n_byte_total;
            r_end_status   <= n_end_status;
        end
    end

endmodule

`default_nettype wire

// File: rtl/xmodem_receiver.sv
// XMODEM receiver top level: configuration registers, protocol core and result queue.
//
// Usage: each input request carries one event (action: start, received byte
// or receive timeout; rx_byte with the byte). The block answers with zero to
// three result requests: a byte to send (C, NAK, ACK or CAN), a tentative
// payload byte, a packet verdict, plus the transfer status and the count of
// accepted payload bytes. o_last marks the final result of one event.
// Configuration (max retransmissions, sync tries) is written through a plain
// write port; max retransmissions is loaded at a start event and on each new packet, sync
// tries is used live.
// Latency: with the queue empty, results of an event appear the cycle after
// it is accepted; later while older results still wait in the queue.
// Throughput: one event per cycle when each event yields at most one result
// and the receiver does not stall; an event that ends in three CAN bytes
// holds the output until all three are taken. The rate is set by the two-entry
// result queue, drained one result a cycle while i_stall is low.
// Reset clears the protocol state to idle, loads the register defaults
// (25 and 16) and empties the result queue. When the receiver stalls, the
// queue fills; once both entries are taken, o_stall rises on the input side.
`default_nettype none

module xmodem_receiver
    import xmr_pkg::*;
#(
    parameter int LARGE_BLOCK_BYTES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_tx_valid,
    output logic [7:0]       o_tx_byte,
    output logic             o_data_valid,
    output logic [7:0]       o_data_byte,
    output logic [1:0]       o_verdict,
    output logic [2:0]       o_status,
    output logic [31:0]      o_received_bytes,
    output logic             o_last
);

    logic [7:0] r_max_retrans;
    logic [7:0] r_sync_tries;
    t_pack      r_fifo [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count, n_count;
    logic [1:0] r_sub;

    logic       accept;
    logic       push;
    logic       pop;
    logic       out_take;
    t_pack      pack;
    t_pack      head;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_retrans <= MAX_RETRANS_RESET;
            r_sync_tries  <= SYNC_TRIES_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_MAX_RETRANS) begin
                r_max_retrans <= i_cfg_data;
            end else begin
                r_sync_tries <= i_cfg_data;
            end
        end
    end

    assign o_stall = (r_count == 2'd2);
    assign accept  = i_valid && !o_stall;

    xmr_core #(
        .LARGE_BLOCK_BYTES(LARGE_BLOCK_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_action     (i_action),
        .i_rx_byte    (i_rx_byte),
        .i_max_retrans(r_max_retrans),
        .i_sync_tries (r_sync_tries),
        .o_pack       (pack),
        .o_push       (push)
    );

    // Result queue: two entries, each expanding to one or three results
    assign head     = r_fifo[r_rd];
    assign o_valid  = (r_count != 2'd0);
    assign o_last   = (r_sub == head.cnt - 2'd1);
    assign out_take = o_valid && !i_stall;
    assign pop      = out_take && o_last;
    assign n_count  = r_count + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr] <= pack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
            r_sub   <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd  <= ~r_rd;
                r_sub <= 2'd0;
            end else if (out_take) begin
                r_sub <= r_sub + 2'd1;
            end
        end
    end

    // Trailing results of a three-CAN reply are plain CAN bytes
    always_comb begin
        if (r_sub == 2'd0) begin
            o_tx_valid   = head.tx_valid;
            o_tx_byte    = head.tx_byte;
            o_data_valid = head.data_valid;
            o_data_byte  = head.data_byte;
            o_verdict    = head.verdict;
        end else begin
            o_tx_valid   = 1'b1;
            o_tx_byte    = CH_CAN;
            o_data_valid = 1'b0;
            o_data_byte  = 8'd0;
            o_verdict    = VD_NONE;
        end
    end

    assign o_status         = head.status;
    assign o_received_bytes = head.total;

    // Checks on the result queue
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result queue count out of range");

    a_head_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (head.cnt == 2'd1 || head.cnt == 2'd3))
        else $error("queued entry has a bad result count");

    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_sub < head.cnt))
        else $error("result index beyond entry");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_count == $past(r_count) - 2'd1))
        else $error("queue did not drain after final result");

    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_tx_valid) |-> (o_tx_byte == 8'd0))
        else $error("send byte not zero without send request");

endmodule

`default_nettype wire
